@@ rtl/hash_set_membership_table_assert.svh @@
// Assertion macros for the hash set membership table.
// HSMT_ASSERT checks a property outside reset; HSMT_ASSERT_ALWAYS checks it on every edge.
`ifndef HASH_SET_MEMBERSHIP_TABLE_ASSERT_SVH
`define HASH_SET_MEMBERSHIP_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define HSMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HSMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSMT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/hsmt_pkg.sv @@
package hsmt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_HASH_BYTES  = 8;

    localparam int CMD_W    = 2;
    localparam int HASH_W   = 64;
    localparam int FILL_W   = 7;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Control from the sequencer to the table.
    typedef struct packed {
        logic wr_en;
        logic scan_start;
    } table_req_t;

    // Scan progress reported back by the table.
    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

@@ rtl/hsmt_table.sv @@
module hsmt_table import hsmt_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int HASH_BYTES  = DEFAULT_HASH_BYTES,
    localparam int KEY_W  = 8 * HASH_BYTES,
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1),
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  table_req_t       req,
    input  logic [CNT_W-1:0] wr_index,
    input  logic [KEY_W-1:0] wr_key,
    input  logic [CNT_W-1:0] scan_len,
    input  logic [KEY_W-1:0] scan_key,
    output scan_stat_t       stat
);

    logic [KEY_W-1:0] entry_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    logic             issuing_reg, issuing_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [KEY_W-1:0] key_reg, key_next;

    logic             hit_now;
    logic             done_now;
    logic [CNT_W-1:0] idx_inc;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            entry_mem[wr_index[ADDR_W-1:0]] <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (issuing_reg) begin
            rd_data_reg <= entry_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign hit_now  = pend_reg && (rd_data_reg == key_reg);
    assign done_now = pend_reg && (hit_now || pend_last_reg);

    // One read is issued per cycle; its data is registered and compared in the next cycle.
    always_comb begin
        issuing_next   = issuing_reg;
        pend_next      = 1'b0;
        pend_last_next = 1'b0;
        idx_next       = idx_reg;
        len_next       = len_reg;
        key_next       = key_reg;
        if (req.scan_start) begin
            issuing_next = 1'b1;
            idx_next     = '0;
            len_next     = scan_len;
            key_next     = scan_key;
        end else if (done_now) begin
            issuing_next = 1'b0;
        end else if (issuing_reg) begin
            pend_next      = 1'b1;
            pend_last_next = (idx_inc == len_reg);
            idx_next       = idx_inc;
            issuing_next   = (idx_inc != len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end else begin
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        key_reg <= key_next;
    end

    assign stat.done = done_now;
    assign stat.hit  = hit_now;

endmodule

@@ rtl/hash_set_membership_table.sv @@
// Add, clear, the unused command code and a query on an empty table: the result state loads the output once it is free.
// Query on N stored entries: one table read per cycle through the single table read port, then the
// result state; the scan ends at the first match, else after all N stored entries are compared.
// One command at a time: the next input transaction is taken the cycle after the result loads.
// Reset (aresetn low, synchronous) empties the table; stored hashes are not cleared.
module hash_set_membership_table import hsmt_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int HASH_BYTES  = DEFAULT_HASH_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [63:0] entry_hash
    input  logic [CMD_W-1:0]    s_tuser,  // [1:0] cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [0] status, [1] found, [8:2] fill_count, rest zero
);

    `include "hash_set_membership_table_assert.svh"

    localparam int KEY_W = 8 * HASH_BYTES;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_status_reg, m_status_next;
    logic             m_found_reg, m_found_next;
    logic [FILL_W-1:0] m_fill_reg, m_fill_next;

    logic       s_fire;
    logic       out_free;
    logic       table_full;
    cmd_t       cmd;
    table_req_t req;
    scan_stat_t stat;

    assign cmd        = cmd_t'(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    hsmt_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HASH_BYTES  (HASH_BYTES)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .wr_index (count_reg),
        .wr_key   (s_tdata[KEY_W-1:0]),
        .scan_len (count_reg),
        .scan_key (s_tdata[KEY_W-1:0]),
        .stat     (stat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (cmd == CMD_QUERY && count_reg != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_fill_next     = m_fill_reg;
        req             = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    case (cmd)
                        CMD_ADD: begin
                            if (table_full) begin
                                res_status_next = 1'b1;
                            end else begin
                                req.wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            req.scan_start = (count_reg != '0);
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (stat.done) begin
                    res_found_next = stat.hit;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    m_fill_next   = FILL_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_fill_reg     <= m_fill_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - FILL_W - 2){1'b0}}, m_fill_reg, m_found_reg, m_status_reg};

    `HSMT_ASSERT(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(TABLE_DEPTH), "fill count above depth")
    `HSMT_ASSERT(a_done_only_in_scan, aclk, aresetn, stat.done |-> state_reg == ST_SCAN, "scan done outside scan state")
    `HSMT_ASSERT(a_add_grows, aclk, aresetn, (s_fire && cmd == CMD_ADD && !table_full) |=> count_reg == $past(count_reg) + CNT_W'(1), "add did not grow table")
    `HSMT_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == ST_IDLE && !m_tvalid_reg, "reset did not idle block")

endmodule
